### rtl/core/mcmp_pkg.sv
// Shared types and constants for the MIDI channel message parser.
package mcmp_pkg;

   localparam int QueueDepth = 4;
   localparam int QueueIdxW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [3:0] {
      ST_START    = 4'd0,
      ST_ON_RUN   = 4'd1,
      ST_ON_HELD  = 4'd2,
      ST_OFF_RUN  = 4'd3,
      ST_OFF_HELD = 4'd4,
      ST_CC_RUN   = 4'd5,
      ST_CC_HELD  = 4'd6,
      ST_PB_RUN   = 4'd7,
      ST_PB_HELD  = 4'd8
   } parse_state_type;

   typedef enum logic [1:0] {
      KIND_NOTE_ON  = 2'd0,
      KIND_NOTE_OFF = 2'd1,
      KIND_CONTROL  = 2'd2,
      KIND_BEND     = 2'd3
   } msg_kind_type;

   typedef enum logic [3:0] {
      STATUS_NOTE_OFF = 4'h8,
      STATUS_NOTE_ON  = 4'h9,
      STATUS_CONTROL  = 4'hB,
      STATUS_BEND     = 4'hE
   } status_nibble_type;

   localparam logic [6:0]  OffVelocity = 7'd63;
   localparam logic [13:0] BendCenter  = 14'(32'h40 << 7);

   // One classified word: a status that selects a running state, or a data byte.
   typedef struct packed {
      logic            status_bit;
      parse_state_type run_state;
      logic [6:0]      data;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } token_port_type;

endpackage

### rtl/core/mcmp_front.sv
// Front end: takes MIDI words, drops foreign and unsupported status, queues the rest.
module mcmp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_midi_byte,
   input  logic                    csr_write_enable,
   input  logic [4:0]              csr_write_data,
   input  logic                    queue_full,
   output mcmp_pkg::token_port_type push
);
   import mcmp_pkg::*;

   logic [4:0]      listen_channel_ff;
   logic [4:0]      listen_channel_in;
   parse_state_type status_state;
   logic            status_bit;
   logic            channel_match;
   logic            keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_channel_ff <= 5'd1;
      end else begin
         listen_channel_ff <= listen_channel_in;
      end
   end

   always_comb begin
      listen_channel_in = csr_write_enable ? csr_write_data : listen_channel_ff;
   end

   always_comb begin
      case (req_midi_byte[7:4])
         STATUS_NOTE_ON:  status_state = ST_ON_RUN;
         STATUS_NOTE_OFF: status_state = ST_OFF_RUN;
         STATUS_CONTROL:  status_state = ST_CC_RUN;
         STATUS_BEND:     status_state = ST_PB_RUN;
         default:         status_state = ST_START;
      endcase
   end

   assign status_bit    = req_midi_byte[7];
   assign channel_match = ({1'b0, req_midi_byte[3:0]} + 5'd1) == listen_channel_ff;
   // Drop status words of other channels or unsupported types right here.
   assign keep = !status_bit || ((status_state != ST_START) && channel_match);

   assign req_stall             = queue_full;
   assign push.valid            = req_valid && !queue_full && keep;
   assign push.token.status_bit = status_bit;
   assign push.token.run_state  = status_state;
   assign push.token.data       = req_midi_byte[6:0];

endmodule

### rtl/core/mcmp_queue.sv
// Short word queue between the front end and the parse engine.
module mcmp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  mcmp_pkg::token_port_type push,
   output logic                     full,
   output mcmp_pkg::token_port_type head,
   input  logic                     pop
);
   import mcmp_pkg::*;

   token_type              mem_ff [QueueDepth];
   logic [QueueIdxW-1:0]   wr_ptr_ff;
   logic [QueueIdxW-1:0]   wr_ptr_in;
   logic [QueueIdxW-1:0]   rd_ptr_ff;
   logic [QueueIdxW-1:0]   rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff;
   logic [QueueCntW-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = count_ff == QueueCntW'(QueueDepth);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QueueIdxW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QueueIdxW'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntW'(do_push) - QueueCntW'(do_pop);
   end

   assign head.valid = count_ff != '0;
   assign head.token = mem_ff[rd_ptr_ff];

endmodule

### rtl/core/mcmp_back.sv
// Parse engine: running-status state machine and the result register.
module mcmp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mcmp_pkg::token_port_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_msg_kind,
   output logic [6:0]               rsp_first_value,
   output logic [6:0]               rsp_second_value,
   output logic signed [13:0]       rsp_bend_value
);
   import mcmp_pkg::*;

   parse_state_type    state_ff;
   parse_state_type    state_in;
   logic [6:0]         held_ff;
   logic [6:0]         held_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   msg_kind_type       kind_ff;
   msg_kind_type       kind_in;
   logic [6:0]         first_ff;
   logic [6:0]         first_in;
   logic [6:0]         second_ff;
   logic [6:0]         second_in;
   logic [13:0]        bend_ff;
   logic [13:0]        bend_in;
   logic               produces;
   logic               out_free;
   logic [6:0]         d;

   assign d        = head.token.data;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      bend_ff   <= bend_in;
   end

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      kind_in   = kind_ff;
      first_in  = first_ff;
      second_in = second_ff;
      bend_in   = bend_ff;
      produces  = 1'b0;
      if (!head.token.status_bit) begin
         case (state_ff)
            ST_ON_HELD, ST_OFF_HELD, ST_CC_HELD, ST_PB_HELD: produces = 1'b1;
            default:                                           produces = 1'b0;
         endcase
      end
      // A word that yields nothing never waits on the result register.
      pop = head.valid && (!produces || out_free);

      if (pop) begin
         if (head.token.status_bit) begin
            state_in = head.token.run_state;
         end else begin
            case (state_ff)
               ST_START: begin
                  state_in = ST_START;
               end
               ST_ON_RUN, ST_OFF_RUN, ST_CC_RUN, ST_PB_RUN: begin
                  held_in  = d;
                  state_in = parse_state_type'(state_ff + 4'd1);
               end
               ST_ON_HELD: begin
                  state_in = ST_ON_RUN;
                  first_in = held_ff;
                  bend_in  = '0;
                  if (d == 7'd0) begin
                     kind_in   = KIND_NOTE_OFF;
                     second_in = OffVelocity;
                  end else begin
                     kind_in   = KIND_NOTE_ON;
                     second_in = d;
                  end
               end
               ST_OFF_HELD: begin
                  state_in  = ST_OFF_RUN;
                  kind_in   = KIND_NOTE_OFF;
                  first_in  = held_ff;
                  second_in = d;
                  bend_in   = '0;
               end
               ST_CC_HELD: begin
                  state_in  = ST_CC_RUN;
                  kind_in   = KIND_CONTROL;
                  first_in  = held_ff;
                  second_in = d;
                  bend_in   = '0;
               end
               ST_PB_HELD: begin
                  state_in  = ST_PB_RUN;
                  kind_in   = KIND_BEND;
                  first_in  = '0;
                  second_in = '0;
                  bend_in   = {d, held_ff} - BendCenter;
               end
               default: begin
                  state_in = ST_START;
               end
            endcase
         end
      end

      if (pop && produces) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_msg_kind     = kind_ff;
   assign rsp_first_value  = first_ff;
   assign rsp_second_value = second_ff;
   assign rsp_bend_value   = bend_ff;

   a_status_selects: assert property (@(posedge clock) disable iff (reset)
      pop && head.token.status_bit |=> state_ff == $past(head.token.run_state))
      else $error("status word did not select its running state");

   a_pair_returns_to_run: assert property (@(posedge clock) disable iff (reset)
      pop && produces |=> (state_ff == ST_ON_RUN || state_ff == ST_OFF_RUN
                           || state_ff == ST_CC_RUN || state_ff == ST_PB_RUN))
      else $error("completed pair did not return to running state");

   a_bend_zero_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_BEND |-> first_ff == '0 && second_ff == '0)
      else $error("pitch bend result carries note values");

   a_note_zero_bend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_BEND |-> bend_ff == '0)
      else $error("non-bend result carries a bend value");

endmodule

### rtl/core/midi_channel_message_parser.sv
// Path: a word accepted on req is written into the queue, then parsed into the result
// register that drives rsp. Throughput: one MIDI word per cycle while the queue is not
// full; results leave at one per cycle while rsp is not stalled.
// A four-word queue between classifier and parse engine absorbs rsp stalls.
// Reset (synchronous, active high): start state, held byte zero, listen channel 1,
// queue and result register empty.
module midi_channel_message_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_midi_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_msg_kind,
   output logic [6:0]         rsp_first_value,
   output logic [6:0]         rsp_second_value,
   output logic signed [13:0] rsp_bend_value,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);
   import mcmp_pkg::*;

   token_port_type push;
   token_port_type head;
   logic           queue_full;
   logic           pop;

   mcmp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_midi_byte    (req_midi_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push)
   );

   mcmp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   mcmp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_msg_kind     (rsp_msg_kind),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_bend_value   (rsp_bend_value)
   );

endmodule

### dv/midi_channel_message_parser_tb.sv
// Self-checking testbench for the MIDI channel message parser: directed table plus random bursts.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mcmp_pkg::*;

   // Status types the parser skips.
   localparam logic [3:0] STATUS_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] STATUS_PROGRAM       = 4'hC;
   localparam logic [3:0] STATUS_CHAN_PRESSURE = 4'hD;
   localparam logic [3:0] STATUS_SYSTEM        = 4'hF;
   localparam logic [3:0] CH1_NIBBLE           = 4'h0;
   localparam logic [3:0] CH2_NIBBLE           = 4'h1;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 10;
   localparam int MAX_REPORTS    = 10;
   localparam int IDLE_PCT       = 23;

   typedef struct packed {
      msg_kind_type      kind;
      logic [6:0]        first;
      logic [6:0]        second;
      logic signed [13:0] bend;
   } midi_msg_type;

   typedef struct packed {
      logic [7:0]   word;
      logic         typed;
      midi_msg_type want;
   } table_row_type;

   localparam midi_msg_type NO_MSG = '0;

   localparam table_row_type DIRECTED_ROWS [25] = '{
      '{8'h45, 1'b0, NO_MSG},                       // data in start state: ignored
      '{{STATUS_NOTE_ON, CH1_NIBBLE}, 1'b0, NO_MSG},
      '{8'h3C, 1'b0, NO_MSG},
      '{8'h64, 1'b1, '{KIND_NOTE_ON, 7'd60, 7'd100, 14'sd0}},
      '{8'h3E, 1'b0, NO_MSG},                       // running status
      '{8'h00, 1'b1, '{KIND_NOTE_OFF, 7'd62, OffVelocity, 14'sd0}},
      '{{STATUS_NOTE_OFF, CH1_NIBBLE}, 1'b0, NO_MSG},
      '{8'h7F, 1'b0, NO_MSG},
      '{8'h7F, 1'b1, '{KIND_NOTE_OFF, 7'd127, 7'd127, 14'sd0}},
      '{{STATUS_CONTROL, CH1_NIBBLE}, 1'b0, NO_MSG},
      '{8'h00, 1'b0, NO_MSG},
      '{8'h00, 1'b1, '{KIND_CONTROL, 7'd0, 7'd0, 14'sd0}},
      '{{STATUS_BEND, CH1_NIBBLE}, 1'b0, NO_MSG},
      '{8'h00, 1'b0, NO_MSG},
      '{8'h00, 1'b1, '{KIND_BEND, 7'd0, 7'd0, 14'sh2000}},   // most negative bend
      '{8'h7F, 1'b0, NO_MSG},
      '{8'h7F, 1'b1, '{KIND_BEND, 7'd0, 7'd0, 14'sd8191}},
      '{8'h00, 1'b0, NO_MSG},
      '{8'h40, 1'b1, '{KIND_BEND, 7'd0, 7'd0, 14'sd0}},      // center
      '{{STATUS_POLY_PRESSURE, CH1_NIBBLE}, 1'b0, NO_MSG},   // unsupported status: skip
      '{{STATUS_NOTE_ON, CH2_NIBBLE}, 1'b0, NO_MSG},         // other channel: skip
      '{8'h05, 1'b0, NO_MSG},
      '{{STATUS_CONTROL, CH1_NIBBLE}, 1'b0, NO_MSG},         // status where data is due
      '{8'h11, 1'b0, NO_MSG},
      '{8'h22, 1'b1, '{KIND_CONTROL, 7'd17, 7'd34, 14'sd0}}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_midi_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_msg_kind;
   logic [6:0]         rsp_first_value;
   logic [6:0]         rsp_second_value;
   logic signed [13:0] rsp_bend_value;
   logic               csr_write_enable = 1'b0;
   logic [4:0]         csr_write_data = '0;

   // Predicted parser state.
   parse_state_type parse_pos = ST_START;
   logic [6:0]      held_byte = '0;
   logic [4:0]      listen_sel = 5'd1;

   midi_msg_type pending_msgs[$];
   int        mismatches = 0;
   int        words_sent = 0;
   int        msgs_seen = 0;
   int        kind_seen [4] = '{0, 0, 0, 0};
   int        settings_used = 1;
   int        send_idle_pct = IDLE_PCT;
   int        rsp_idle_pct = IDLE_PCT;
   bit        hold_request = 1'b0;
   int        quiet_cycles = 0;

   midi_channel_message_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_midi_byte    (req_midi_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_msg_kind     (rsp_msg_kind),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_bend_value   (rsp_bend_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Advance the predicted parser by one word; return 1 when a message completes.
   function automatic bit parse_midi_word(input logic [7:0] word, output midi_msg_type msg);
      logic [6:0]      data;
      parse_state_type run;
      data = word[6:0];
      msg = NO_MSG;
      if (word[7]) begin
         case (word[7:4])
            STATUS_NOTE_ON:  run = ST_ON_RUN;
            STATUS_NOTE_OFF: run = ST_OFF_RUN;
            STATUS_CONTROL:  run = ST_CC_RUN;
            STATUS_BEND:     run = ST_PB_RUN;
            default:         return 1'b0;
         endcase
         if ({1'b0, word[3:0]} + 5'd1 != listen_sel) return 1'b0;
         parse_pos = run;
         return 1'b0;
      end
      case (parse_pos)
         ST_ON_RUN, ST_OFF_RUN, ST_CC_RUN, ST_PB_RUN: begin
            held_byte = data;
            parse_pos = parse_state_type'(parse_pos + 4'd1);
            return 1'b0;
         end
         ST_ON_HELD: begin
            parse_pos = ST_ON_RUN;
            msg.kind = (data == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            msg.first = held_byte;
            msg.second = (data == 7'd0) ? OffVelocity : data;
            return 1'b1;
         end
         ST_OFF_HELD: begin
            parse_pos = ST_OFF_RUN;
            msg.kind = KIND_NOTE_OFF;
            msg.first = held_byte;
            msg.second = data;
            return 1'b1;
         end
         ST_CC_HELD: begin
            parse_pos = ST_CC_RUN;
            msg.kind = KIND_CONTROL;
            msg.first = held_byte;
            msg.second = data;
            return 1'b1;
         end
         ST_PB_HELD: begin
            parse_pos = ST_PB_RUN;
            msg.kind = KIND_BEND;
            msg.bend = signed'({data, held_byte} - BendCenter);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Offer one word, wait for it to be taken, then record what it should produce.
   task automatic push_word(input logic [7:0] word, input bit typed = 1'b0,
                            input midi_msg_type want = NO_MSG);
      int           gap;
      midi_msg_type msg;
      bit           has_msg;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_midi_byte <= word;
      do @(posedge clock); while (req_stall);
      words_sent++;
      has_msg = parse_midi_word(word, msg);
      if (typed) pending_msgs.push_back(want);
      else if (has_msg) pending_msgs.push_back(msg);
   endtask

   // Drop valid, wait out every expected message, then let in-flight words drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_listen(input logic [4:0] chan);
      csr_write_enable <= 1'b1;
      csr_write_data <= chan;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      listen_sel = chan;
      settings_used++;
   endtask

   function automatic logic [3:0] pick_voice_status();
      case ($urandom_range(3))
         0:       return STATUS_NOTE_ON;
         1:       return STATUS_NOTE_OFF;
         2:       return STATUS_CONTROL;
         default: return STATUS_BEND;
      endcase
   endfunction

   function automatic logic [3:0] pick_skipped_status();
      case ($urandom_range(3))
         0:       return STATUS_POLY_PRESSURE;
         1:       return STATUS_PROGRAM;
         2:       return STATUS_CHAN_PRESSURE;
         default: return STATUS_SYSTEM;
      endcase
   endfunction

   // Mostly uniform, with the extremes (zero velocity among them) a bit more often.
   function automatic logic [7:0] rand_data();
      if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'h7F : 8'h00;
      return 8'($urandom_range(127));
   endfunction

   task automatic send_burst();
      int         pick;
      logic [3:0] chan_nib;
      if (listen_sel >= 5'd1 && listen_sel <= 5'd16) chan_nib = 4'(listen_sel - 5'd1);
      else chan_nib = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 70) begin
         // well-formed: optional status, then one to four data pairs
         if ($urandom_range(3) != 0) push_word({pick_voice_status(), chan_nib});
         repeat ($urandom_range(1, 4)) begin
            push_word(rand_data());
            push_word(rand_data());
         end
      end else if (pick < 80) begin
         // leave a pair half done; the next status cuts it off
         push_word({pick_voice_status(), chan_nib});
         push_word(rand_data());
      end else if (pick < 90) begin
         push_word({pick_voice_status(), chan_nib + 4'($urandom_range(1, 15))});
      end else if (pick < 95) begin
         push_word({pick_skipped_status(), 4'($urandom_range(15))});
      end else begin
         push_word(8'($urandom_range(255)));
      end
   endtask

   task automatic run_phase(input logic [4:0] chan, input int n_words, input int calm_words,
                            input bit with_hold);
      int stop_at;
      int calm_until;
      int hold_at;
      write_listen(chan);
      stop_at = words_sent + n_words;
      calm_until = words_sent + calm_words;
      hold_at = words_sent + n_words / 4;
      while (words_sent < stop_at) begin
         send_idle_pct = (words_sent < calm_until) ? 0 : IDLE_PCT;
         rsp_idle_pct = send_idle_pct;
         if (with_hold && words_sent >= hold_at) begin
            hold_request = 1'b1;
            with_hold = 1'b0;
         end
         send_burst();
      end
      settle();
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[i])
         push_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      settle();
      run_phase(5'd16, 450, 200, 1'b0);
      run_phase(5'($urandom_range(2, 15)), 450, 0, 1'b1);
      run_phase(5'd0, 150, 0, 1'b0);
      run_phase(5'd31, 150, 0, 1'b0);
      run_phase(5'd1, 500, 0, 1'b0);
      $display("Sent %0d MIDI words over %0d channel settings; checked %0d messages",
               words_sent, settings_used, msgs_seen);
      $display("(%0d note on, %0d note off, %0d control, %0d bend), %0d mismatches.",
               kind_seen[KIND_NOTE_ON], kind_seen[KIND_NOTE_OFF], kind_seen[KIND_CONTROL],
               kind_seen[KIND_BEND], mismatches);
      if (mismatches == 0 && pending_msgs.size() == 0) begin
         $display("** midi_channel_message_parser: PASSED **");
      end else begin
         $display("** midi_channel_message_parser: FAILED **");
      end
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   function automatic void report_mismatch(input string what, input midi_msg_type want);
      string want_s;
      string got_s;
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         want_s = $sformatf("kind=%0d first=%0d second=%0d bend=%0d",
                            want.kind, want.first, want.second, want.bend);
         got_s = $sformatf("kind=%0d first=%0d second=%0d bend=%0d",
                           rsp_msg_kind, rsp_first_value, rsp_second_value, rsp_bend_value);
         $display("ERROR %0t: %s: expected %s, got %s", $realtime, what, want_s, got_s);
      end
   endfunction

   always @(posedge clock) begin : message_check
      midi_msg_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         msgs_seen++;
         kind_seen[rsp_msg_kind]++;
         if (pending_msgs.size() == 0) begin
            report_mismatch("message with none expected", NO_MSG);
         end else begin
            want = pending_msgs.pop_front();
            if (rsp_msg_kind != want.kind || rsp_first_value != want.first ||
                rsp_second_value != want.second || rsp_bend_value != want.bend)
               report_mismatch("field mismatch", want);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles, %0d messages still expected.",
                  WATCHDOG_LIMIT, pending_msgs.size());
         $display("** midi_channel_message_parser: FAILED **");
         $finish;
      end
   end

endmodule
